### rtl/bis_pkg.sv
// Shared types and constants of the bounded integer set store.
package bis_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int COUNT_W     = 7;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int EXT_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Search token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               action;
        logic [VALUE_W-1:0] key;
        logic               found;
        logic               placed;
        logic [CNT_W-1:0]   left;
    } t_token;

endpackage

### rtl/bounded_integer_set_store.sv
// Top level of the bounded integer set store: control, capacity register and cell row.
//
// The block keeps a set of distinct 32-bit values packed into a row of 64 cells. An item
// is accepted at a rising edge with i_start high and o_busy low; its result (status and
// the element count after the access) appears on o_status and o_count for exactly one
// cycle, marked by o_valid, and the receiver cannot stall it. An insert refused as full
// answers in the cycle after acceptance and leaves the block free at once. Every other
// item sends a search token through the row of cells, one cell per clock, so its result
// comes once the token has passed all cells and the result register; o_busy stays high
// until the token leaves the last cell. A new item may be started in the cycle its
// predecessor's result is shown. The user must write the capacity register with i_cfg_we
// and i_cfg_data only while the block is idle; the block does not enforce this. It resets
// to 64 and values above MAX_ENTRIES act as MAX_ENTRIES. Lowering it below the current
// count keeps the stored elements; inserts answer full until removes bring the count below it.
module bounded_integer_set_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_action,
    input  logic signed [31:0]           i_value,
    input  logic                         i_cfg_we,
    input  logic [6:0]                   i_cfg_data,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [6:0]                   o_count
);
    import bis_pkg::*;

    logic [CAP_W-1:0]    r_capacity;
    logic [CNT_W-1:0]    r_held;
    logic [CNT_W-1:0]    n_held;
    logic                r_busy;
    logic                r_valid;
    t_status             r_status;
    t_status             n_status;
    logic [COUNT_W-1:0]  r_count;
    logic [EXT_W-1:0]    eff_cap;
    logic                accept;
    logic                is_full;
    logic                launch;
    t_token              launch_tok;
    t_token              done_tok;

    // The effective capacity is the smaller of the register and the row length.
    always_comb begin
        if (EXT_W'(r_capacity) > EXT_W'(MAX_ENTRIES)) begin
            eff_cap = EXT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = EXT_W'(r_capacity);
        end
    end

    assign accept  = i_start && !r_busy;
    assign is_full = (EXT_W'(r_held) >= eff_cap);
    // A full insert never enters the row; it is answered directly.
    assign launch  = accept && !((i_action == ACT_INSERT) && is_full);

    always_comb begin
        launch_tok        = '0;
        launch_tok.valid  = launch;
        launch_tok.action = i_action;
        launch_tok.key    = i_value;
        launch_tok.left   = r_held;
    end

    bis_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (launch_tok),
        .o_tok   (done_tok)
    );

    // Result of the token leaving the last cell, or of a refused insert.
    always_comb begin
        n_held   = r_held;
        n_status = ST_FULL;
        if (done_tok.valid) begin
            if (done_tok.action == ACT_INSERT) begin
                if (done_tok.found) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_status = ST_INSERTED;
                    n_held   = r_held + CNT_W'(1);
                end
            end else begin
                if (done_tok.found) begin
                    n_status = ST_REMOVED;
                    n_held   = r_held - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(64);
            r_held     <= '0;
            r_busy     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_held  <= n_held;
            r_valid <= done_tok.valid || (accept && !launch);
            if (launch) begin
                r_busy <= 1'b1;
            end else if (done_tok.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_tok.valid || (accept && !launch)) begin
            r_status <= n_status;
            r_count  <= COUNT_W'(n_held);
        end
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_count  = r_count;

endmodule

### rtl/bis_cell.sv
// One storage cell: holds one element, compares it with the passing token and shifts or writes.
module bis_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bis_pkg::t_token             i_tok,
    input  logic [bis_pkg::VALUE_W-1:0] i_next_elem,
    output bis_pkg::t_token             o_tok,
    output logic [bis_pkg::VALUE_W-1:0] o_elem
);
    import bis_pkg::*;

    t_token             r_tok;
    t_token             n_tok;
    logic [VALUE_W-1:0] r_elem;
    logic               in_range;
    logic               match;
    logic               found_out;
    logic               write_here;
    logic               shift_here;

    always_comb begin
        in_range   = (i_tok.left != '0);
        match      = i_tok.valid && in_range && (r_elem == i_tok.key);
        found_out  = i_tok.found || match;
        write_here = i_tok.valid && (i_tok.action == ACT_INSERT) && !i_tok.found
                     && !in_range && !i_tok.placed;
        shift_here = i_tok.valid && (i_tok.action == ACT_REMOVE) && found_out && in_range;

        n_tok        = i_tok;
        n_tok.found  = found_out;
        n_tok.placed = i_tok.placed || write_here;
        n_tok.left   = in_range ? (i_tok.left - CNT_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_here) begin
            r_elem <= i_tok.key;
        end else if (shift_here) begin
            r_elem <= i_next_elem;
        end
    end

    assign o_tok  = r_tok;
    assign o_elem = r_elem;

endmodule

### rtl/bis_chain.sv
// The row of storage cells, each linked to its neighbors.
module bis_chain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bis_pkg::t_token i_tok,
    output bis_pkg::t_token o_tok
);
    import bis_pkg::*;

    t_token             tok  [MAX_ENTRIES+1];
    logic [VALUE_W-1:0] elem [MAX_ENTRIES+1];

    assign tok[0]            = i_tok;
    assign elem[MAX_ENTRIES] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        bis_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_next_elem (elem[g+1]),
            .o_tok       (tok[g+1]),
            .o_elem      (elem[g])
        );
    end

    assign o_tok = tok[MAX_ENTRIES];

endmodule

### sim/set_access_checker.sv
// Checker for the set store: predicts each access, compares results, counts failures.
`timescale 1ns / 100ps

module set_access_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_action,
    input  logic [bis_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_cfg_we,
    input  logic [bis_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    input  logic [2:0]                  i_status,
    input  logic [bis_pkg::COUNT_W-1:0] i_count,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bis_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_set_result;

    // Private copy of the stored set and of the capacity register.
    logic [VALUE_W-1:0] members [MAX_ENTRIES];
    int                 n_members = 0;
    int                 cap_reg   = MAX_ENTRIES;
    t_set_result        due_q [$];
    t_set_result        oldest;
    int                 n_fail    = 0;

    // Applies one access to the private set and returns the answer it must give.
    function automatic t_set_result apply_access(input logic act,
                                                 input logic [VALUE_W-1:0] v);
        int          room;
        int          pos;
        t_set_result r;
        room = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
        pos  = n_members;
        for (int i = n_members - 1; i >= 0; i--) begin
            if (members[i] == v) begin
                pos = i;
            end
        end
        if (act == ACT_INSERT) begin
            if (n_members >= room) begin
                r.status = ST_FULL;
            end else if (pos < n_members) begin
                r.status = ST_DUPLICATE;
            end else begin
                members[n_members] = v;
                n_members++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (pos >= n_members) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (int j = pos; j < n_members - 1; j++) begin
                    members[j] = members[j + 1];
                end
                n_members--;
                r.status = ST_REMOVED;
            end
        end
        r.count = COUNT_W'(n_members);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_members = 0;
            cap_reg   = MAX_ENTRIES;
            due_q.delete();
        end else begin
            // A result always belongs to an access accepted at an earlier edge.
            if (i_valid === 1'b1) begin
                if (due_q.size() == 0) begin
                    $error("unexpected result: status %0d count %0d", i_status, i_count);
                    n_fail++;
                end else begin
                    oldest = due_q.pop_front();
                    if (i_status !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, i_status);
                        n_fail++;
                    end
                    if (i_count !== oldest.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               oldest.count, i_count);
                        n_fail++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                due_q.push_back(apply_access(i_action, i_value));
            end
            if (i_cfg_we === 1'b1) begin
                cap_reg = i_cfg_data;
            end
        end
        o_pending    <= due_q.size();
        o_fail_count <= n_fail;
    end

endmodule

### sim/tb_bounded_integer_set_store.sv
// Testbench top for the bounded integer set store: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_bounded_integer_set_store;
    import bis_pkg::*;

    // A slow access and the longest sender gap both stay well inside this limit, so a quiet
    // stretch this long can only mean the block has hung.
    localparam int WATCHDOG_LIMIT = 1500;
    // After the last result we keep watching for a while in case a stray result shows up.
    localparam int TAIL_CYCLES    = 2 * (MAX_ENTRIES + 1);
    localparam int POOL_SIZE      = 96;
    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 84;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    logic               action   = ACT_INSERT;
    logic [VALUE_W-1:0] value    = '0;
    logic               cfg_we   = 1'b0;
    logic [CAP_W-1:0]   cfg_data = '0;
    logic               res_valid;
    logic [2:0]         res_status;
    logic [COUNT_W-1:0] res_count;
    int                 fail_count;
    int                 pending;
    int                 stall_cycles = 0;

    // Values that the random part draws from most of the time. The pool is larger
    // than the set can hold, so inserts fill it up, and drawing from it again gives
    // duplicates and removes that actually find something.
    logic [VALUE_W-1:0] pool [POOL_SIZE];

    bounded_integer_set_store DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_action   (action),
        .i_value    (value),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_valid    (res_valid),
        .o_status   (res_status),
        .o_count    (res_count)
    );

    set_access_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (action),
        .i_value      (value),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_valid      (res_valid),
        .i_status     (res_status),
        .i_count      (res_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The watchdog counts cycles in which neither an item nor a result moves.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drops start and waits, at falling edges, until every result has come back and
    // the block reports itself free. Returns at a falling edge.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy !== 1'b0) begin
            @(negedge clk);
        end
    endtask

    // The capacity register is only written once the block has gone quiet.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_we   = 1'b1;
        cfg_data = cap;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = CAP_W'($urandom);
    endtask

    // Offers one item after a gap of the given number of cycles and returns at the
    // rising edge that accepts it. Start stays high from one item to the next when
    // there is no gap, so back-to-back acceptance is exercised too.
    task automatic send_item(input logic act, input logic [VALUE_W-1:0] v, input int gap);
        @(negedge clk);
        if (gap > 0) begin
            start = 1'b0;
            // The payload lines carry noise while start is low.
            action = 1'($urandom);
            value  = $urandom;
            repeat (gap) @(negedge clk);
        end
        start  = 1'b1;
        action = act;
        value  = v;
        do begin
            @(posedge clk);
        end while (busy !== 1'b0);
    endtask

    // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
    function automatic int pick_gap(input bit no_gaps);
        int roll;
        if (no_gaps) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) begin
            return pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    initial begin
        // Capacities for the random phases: above the row length, the row length, tiny
        // values, zero, and values that land below a count left by the phase before.
        logic [CAP_W-1:0] phase_cap [N_PHASES];
        bit               filling;
        bit               no_gaps;
        int               run_left;
        logic             act;

        phase_cap = '{7'd127, 7'd64, 7'd3, 7'd0, 7'd100, 7'd1, 7'd37, 7'd65, 7'd64};

        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        pool[4] = 32'h0000_0001;
        pool[5] = 32'h8000_0001;
        for (int i = 6; i < POOL_SIZE; i++) begin
            pool[i] = $urandom;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity. Extremes of the value range go in; a
        // duplicate is refused; a remove from the middle shifts later entries down; an
        // absent value is not found, on a partly filled set and on an empty one.
        send_item(ACT_INSERT, 32'h8000_0000, 0);
        send_item(ACT_INSERT, 32'h7FFF_FFFF, 0);
        send_item(ACT_INSERT, 32'h0000_0000, 2);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 0);
        send_item(ACT_INSERT, 32'h8000_0000, 0);
        send_item(ACT_REMOVE, 32'h0000_0000, 1);
        send_item(ACT_REMOVE, 32'h0000_0005, 0);
        send_item(ACT_REMOVE, 32'h7FFF_FFFF, 0);
        send_item(ACT_INSERT, 32'h7FFF_FFFF, 0);
        send_item(ACT_REMOVE, 32'h8000_0000, 0);
        send_item(ACT_REMOVE, 32'hFFFF_FFFF, 3);
        send_item(ACT_REMOVE, 32'h7FFF_FFFF, 0);
        send_item(ACT_REMOVE, 32'hFFFF_FFFF, 0);

        // With no room at all every insert answers full.
        set_capacity(7'd0);
        send_item(ACT_INSERT, 32'h0000_0007, 0);
        send_item(ACT_REMOVE, 32'h0000_0007, 0);

        // A full set refuses even a value it already holds.
        set_capacity(7'd2);
        send_item(ACT_INSERT, 32'h0000_000A, 0);
        send_item(ACT_INSERT, 32'h0000_0014, 0);
        send_item(ACT_INSERT, 32'h0000_000A, 0);
        send_item(ACT_INSERT, 32'h0000_001E, 0);

        // Capacity dropped below the count: elements stay, inserts stay refused until
        // removes bring the count under the new limit.
        set_capacity(7'd1);
        send_item(ACT_INSERT, 32'h0000_0028, 0);
        send_item(ACT_REMOVE, 32'h0000_000A, 0);
        send_item(ACT_INSERT, 32'h0000_001E, 0);
        send_item(ACT_REMOVE, 32'h0000_0014, 0);
        send_item(ACT_INSERT, 32'h0000_001E, 0);

        // Random phases. Each runs at its own capacity and alternates between filling
        // and draining runs, so the set swings between empty and full. Values come
        // mostly from the pool; the rest are fresh random words.
        filling  = 1'b1;
        run_left = $urandom_range(15, 60);
        for (int p = 0; p < N_PHASES; p++) begin
            set_capacity(phase_cap[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(15, 60);
                end
                run_left--;
                if ($urandom_range(0, 99) < (filling ? 80 : 20)) begin
                    act = ACT_INSERT;
                end else begin
                    act = ACT_REMOVE;
                end
                // Now and then the sender holds off until every result is back.
                if ($urandom_range(0, 49) == 0) begin
                    wait_idle();
                end
                send_item(act, pick_value(act == ACT_INSERT ? 85 : 90), pick_gap(no_gaps));
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
